@@ hdl/rdd_pkg.sv @@
// shared types and constants for the reversible deque drain block
`timescale 1ns / 1ps
`default_nettype none

package rdd_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int VALUE_BITS_DEFAULT = 8;
    localparam int DATA_W             = 8;
    localparam int FUNC_W             = 2;
    localparam int RES_USER_W         = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH    = 2'd0,
        FUNC_REVERSE = 2'd1,
        FUNC_DROP    = 2'd2,
        FUNC_FINISH  = 2'd3
    } func_t;

    typedef enum logic {
        CMD_FULL_ERR = 1'b0,
        CMD_DRAIN    = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        logic              error;
        logic              list_empty;
        logic              last;
        logic [DATA_W-1:0] element;
    } res_t;

endpackage

`default_nettype wire

@@ hdl/reversible_deque_drain_core.sv @@
// Bounded double-ended queue with lazy reversal and a drain on finish.
// Input words on s_axis: tuser carries the function (push, reverse, drop,
// finish), tdata the value to push. Result words on m_axis: tdata is the
// element, tlast marks the final word of a drain, tuser carries list_empty
// and error.
// Push, reverse and drop are taken one a cycle while tready is high and give
// no result, except a push to a full queue, which queues an error word right
// away.
// A finish queues a drain command and clears pointers, direction and error
// when it is taken; the input side then holds tready low until the back part
// has read every held element out. Each drained element passes two steps, a
// store read and then an output load, because the store has a registered
// read port. An empty or failed drain gives one word.
// The output register lets the back part keep one word ready while the
// receiver stalls; the back part waits on it and the command queue (two
// entries) then fills, after which tready drops.
// Reset (aresetn low, synchronous) empties the queue and clears pointers,
// direction and error; store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module reversible_deque_drain_core #(
    parameter int DEPTH      = rdd_pkg::DEPTH_DEFAULT,
    parameter int VALUE_BITS = rdd_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [rdd_pkg::DATA_W-1:0]     s_axis_tdata,  // [7:0] value
    input  wire logic [rdd_pkg::FUNC_W-1:0]     s_axis_tuser,  // [1:0] func
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [rdd_pkg::DATA_W-1:0]     m_axis_tdata,  // [7:0] element
    output logic                                m_axis_tlast,
    output logic      [rdd_pkg::RES_USER_W-1:0] m_axis_tuser   // [0] list_empty, [1] error
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMD_W = 3 + PTR_W + CNT_W;

    logic                  q_push, q_ready, q_pop, q_valid;
    logic [CMD_W-1:0]      q_wdata, q_rdata;
    logic                  drain_done;
    logic                  ram_we, ram_re;
    logic [PTR_W-1:0]      ram_waddr, ram_raddr;
    logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;
    rdd_pkg::res_t         res;

    rdd_front #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .PTR_W      (PTR_W),
        .CNT_W      (CNT_W),
        .CMD_W      (CMD_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_push        (q_push),
        .q_data        (q_wdata),
        .q_ready       (q_ready),
        .drain_done    (drain_done),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata)
    );

    rdd_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .ready     (q_ready),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .valid     (q_valid)
    );

    rdd_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rdd_back #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .PTR_W      (PTR_W),
        .CNT_W      (CNT_W),
        .CMD_W      (CMD_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .drain_done (drain_done),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    assign m_axis_tdata = res.element;
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = {res.error, res.list_empty};

endmodule

`default_nettype wire

@@ hdl/rdd_ram.sv @@
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module rdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/rdd_queue.sv @@
// two-entry command queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none

module rdd_queue #(
    parameter int WIDTH = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  ready,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  valid
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       fill_reg, fill_next;

    assign ready    = (fill_reg != 2'd2);
    assign valid    = (fill_reg != 2'd0);
    assign pop_data = entry_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (push && ready) begin
            wptr_next = ~wptr_reg;
        end
        if (pop && valid) begin
            rptr_next = ~rptr_reg;
        end
        unique case ({push && ready, pop && valid})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && ready) begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rdd_front.sv @@
// front part: accepts words, keeps the deque pointers and writes pushed values
`timescale 1ns / 1ps
`default_nettype none

module rdd_front #(
    parameter int DEPTH      = rdd_pkg::DEPTH_DEFAULT,
    parameter int VALUE_BITS = rdd_pkg::VALUE_BITS_DEFAULT,
    parameter int PTR_W      = $clog2(DEPTH),
    parameter int CNT_W      = $clog2(DEPTH + 1),
    parameter int CMD_W      = 3 + PTR_W + CNT_W
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [rdd_pkg::DATA_W-1:0] s_axis_tdata,
    input  wire logic [rdd_pkg::FUNC_W-1:0] s_axis_tuser,
    output logic                            q_push,
    output logic      [CMD_W-1:0]           q_data,
    input  wire logic                       q_ready,
    input  wire logic                       drain_done,
    output logic                            ram_we,
    output logic      [PTR_W-1:0]           ram_waddr,
    output logic      [VALUE_BITS-1:0]      ram_wdata
);

    localparam int SW = CNT_W + 1;
    localparam logic [SW-1:0]    DEPTH_S = SW'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef struct packed {
        rdd_pkg::cmd_kind_t kind;
        logic               failed;
        logic               rev;
        logic [PTR_W-1:0]   head;
        logic [CNT_W-1:0]   count;
    } cmd_t;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rev_reg, rev_next;
    logic             failed_reg, failed_next;
    logic             busy_reg, busy_next;

    logic                                 accept;
    rdd_pkg::func_t                       func;
    logic                                 full;
    logic [SW-1:0]                        tail_sum, tail_wrap, head_inc, head_wrap;
    logic [VALUE_BITS+rdd_pkg::DATA_W-1:0] value_ext;
    cmd_t                                 cmd;

    assign s_axis_tready = !busy_reg && q_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign func          = rdd_pkg::func_t'(s_axis_tuser);
    assign full          = (count_reg == DEPTH_C);

    // physical tail and front advance, both wrap at the store depth
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_wrap = (tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum;
    assign head_inc  = SW'(head_reg) + SW'(1);
    assign head_wrap = (head_inc >= DEPTH_S) ? head_inc - DEPTH_S : head_inc;

    assign value_ext = {{VALUE_BITS{1'b0}}, s_axis_tdata};
    assign ram_wdata = value_ext[VALUE_BITS-1:0];
    assign ram_waddr = tail_wrap[PTR_W-1:0];
    assign ram_we    = accept && (func == rdd_pkg::FUNC_PUSH) && !full;

    always_comb begin
        cmd.kind   = (func == rdd_pkg::FUNC_FINISH) ? rdd_pkg::CMD_DRAIN
                                                    : rdd_pkg::CMD_FULL_ERR;
        cmd.failed = failed_reg;
        cmd.rev    = rev_reg;
        cmd.head   = head_reg;
        cmd.count  = count_reg;
    end

    assign q_data = cmd;

    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        failed_next = failed_reg;
        busy_next   = busy_reg;
        q_push      = 1'b0;
        if (drain_done) begin
            busy_next = 1'b0;
        end
        if (accept) begin
            unique case (func)
                rdd_pkg::FUNC_PUSH: begin
                    if (full) begin
                        q_push = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                rdd_pkg::FUNC_REVERSE: begin
                    if (!failed_reg) begin
                        rev_next = ~rev_reg;
                    end
                end
                rdd_pkg::FUNC_DROP: begin
                    if (!failed_reg) begin
                        if (count_reg == '0) begin
                            failed_next = 1'b1;
                        end else begin
                            count_next = count_reg - CNT_W'(1);
                            if (!rev_reg) begin
                                head_next = head_wrap[PTR_W-1:0];
                            end
                        end
                    end
                end
                rdd_pkg::FUNC_FINISH: begin
                    q_push      = 1'b1;
                    head_next   = '0;
                    count_next  = '0;
                    rev_next    = 1'b0;
                    failed_next = 1'b0;
                    busy_next   = 1'b1;
                end
                default: begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            count_reg  <= '0;
            rev_reg    <= 1'b0;
            failed_reg <= 1'b0;
            busy_reg   <= 1'b0;
        end else begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            rev_reg    <= rev_next;
            failed_reg <= failed_next;
            busy_reg   <= busy_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("fill count beyond depth");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && func == rdd_pkg::FUNC_FINISH
        |=> busy_reg && count_reg == '0 && !failed_reg && !rev_reg)
        else $error("finish did not clear state");

    a_full_push_flagged: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && func == rdd_pkg::FUNC_PUSH && full |-> q_push && !ram_we)
        else $error("push to full deque not flagged");

endmodule

`default_nettype wire

@@ hdl/rdd_back.sv @@
// back part: runs queued commands, reads the store and drives the output register
`timescale 1ns / 1ps
`default_nettype none

module rdd_back #(
    parameter int DEPTH      = rdd_pkg::DEPTH_DEFAULT,
    parameter int VALUE_BITS = rdd_pkg::VALUE_BITS_DEFAULT,
    parameter int PTR_W      = $clog2(DEPTH),
    parameter int CNT_W      = $clog2(DEPTH + 1),
    parameter int CMD_W      = 3 + PTR_W + CNT_W
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_valid,
    input  wire logic [CMD_W-1:0]      q_data,
    output logic                       q_pop,
    output logic                       drain_done,
    output logic                       ram_re,
    output logic      [PTR_W-1:0]      ram_raddr,
    input  wire logic [VALUE_BITS-1:0] ram_rdata,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output rdd_pkg::res_t              res
);

    localparam int SW = CNT_W + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

    typedef struct packed {
        rdd_pkg::cmd_kind_t kind;
        logic               failed;
        logic               rev;
        logic [PTR_W-1:0]   head;
        logic [CNT_W-1:0]   count;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_EMIT   = 4'b0100,
        ST_SINGLE = 4'b1000
    } state_t;

    state_t                                state_reg, state_next;
    cmd_t                                  cmd_reg, cmd_next;
    logic [CNT_W-1:0]                      idx_reg, idx_next;
    logic                                  out_valid_reg, out_valid_next;
    rdd_pkg::res_t                         out_reg, out_next;

    cmd_t                                  cmd_in;
    logic                                  slot_free;
    logic                                  is_last;
    logic [CNT_W-1:0]                      pos;
    logic [SW-1:0]                         addr_sum, addr_wrap;
    logic [VALUE_BITS+rdd_pkg::DATA_W-1:0] rdata_ext;

    assign cmd_in    = cmd_t'(q_data);
    assign slot_free = !out_valid_reg || res_ready;
    assign is_last   = (idx_reg + CNT_W'(1) == cmd_reg.count);

    // logical position to store index, reading backward while reversed
    assign pos       = cmd_reg.rev ? cmd_reg.count - CNT_W'(1) - idx_reg : idx_reg;
    assign addr_sum  = SW'(cmd_reg.head) + SW'(pos);
    assign addr_wrap = (addr_sum >= DEPTH_S) ? addr_sum - DEPTH_S : addr_sum;
    assign ram_raddr = addr_wrap[PTR_W-1:0];
    assign ram_re    = (state_reg == ST_READ);

    assign rdata_ext = {{rdd_pkg::DATA_W{1'b0}}, ram_rdata};

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        drain_done     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cmd_next = cmd_in;
                    idx_next = '0;
                    if (cmd_in.kind == rdd_pkg::CMD_FULL_ERR || cmd_in.failed
                            || cmd_in.count == '0) begin
                        state_next = ST_SINGLE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_valid_next        = 1'b1;
                    out_next.element      = rdata_ext[rdd_pkg::DATA_W-1:0];
                    out_next.last         = is_last;
                    out_next.list_empty   = 1'b0;
                    out_next.error        = 1'b0;
                    if (is_last) begin
                        drain_done = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_SINGLE: begin
                if (slot_free) begin
                    out_valid_next   = 1'b1;
                    out_next.element = '0;
                    if (cmd_reg.kind == rdd_pkg::CMD_FULL_ERR) begin
                        out_next.last       = 1'b0;
                        out_next.list_empty = 1'b0;
                        out_next.error      = 1'b1;
                    end else begin
                        out_next.last       = 1'b1;
                        out_next.list_empty = !cmd_reg.failed;
                        out_next.error      = cmd_reg.failed;
                        drain_done          = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        out_reg <= out_next;
    end

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> idx_reg < cmd_reg.count)
        else $error("drain index beyond fill count");

    a_done_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_done |=> out_valid_reg && out_reg.last)
        else $error("drain finished without a last word");

    a_done_only_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_done |-> cmd_reg.kind == rdd_pkg::CMD_DRAIN)
        else $error("drain done raised for an error command");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the reversible deque drain core
`timescale 1ns / 1ps

module tb;

    localparam int QUEUE_DEPTH = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 20;
    localparam int ITEM_TARGET = 165;

    logic                           aclk          = 1'b0;
    logic                           aresetn       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [rdd_pkg::DATA_W-1:0]     s_axis_tdata  = '0;     // [7:0] value
    logic [rdd_pkg::FUNC_W-1:0]     s_axis_tuser  = '0;     // [1:0] func
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [rdd_pkg::DATA_W-1:0]     m_axis_tdata;           // [7:0] element
    logic                           m_axis_tlast;
    logic [rdd_pkg::RES_USER_W-1:0] m_axis_tuser;           // [0] list_empty, [1] error

    reversible_deque_drain_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow deque
    logic [rdd_pkg::DATA_W-1:0] shadow_store [QUEUE_DEPTH];
    logic [5:0]                 front_idx  = '0;
    int                         held       = 0;
    bit                         backward   = 1'b0;
    bit                         failed     = 1'b0;

    rdd_pkg::res_t drain_words [$];

    int  mismatches   = 0;
    int  words_in     = 0;
    int  words_out    = 0;
    int  drains       = 0;
    int  full_pushes  = 0;
    int  idle_cycles  = 0;
    bit  steady       = 1'b0;

    function automatic rdd_pkg::res_t make_word(logic [7:0] el, bit lst, bit empty, bit err);
        rdd_pkg::res_t r;
        r.element    = el;
        r.last       = lst;
        r.list_empty = empty;
        r.error      = err;
        return r;
    endfunction

    // append one predicted word at the tail of the expected list
    function automatic void add_word(rdd_pkg::res_t w);
        drain_words.insert(drain_words.size(), w);
    endfunction

    task automatic deque_apply(input rdd_pkg::func_t f, input logic [7:0] v);
        int         i;
        int         pos;
        logic [5:0] idx;
        case (f)
            rdd_pkg::FUNC_PUSH: begin
                if (held >= QUEUE_DEPTH) begin
                    add_word(make_word(8'h00, 1'b0, 1'b0, 1'b1));
                    full_pushes++;
                end else begin
                    idx = front_idx + held[5:0];
                    shadow_store[idx] = v;
                    held++;
                end
            end
            rdd_pkg::FUNC_REVERSE: begin
                if (!failed) backward = !backward;
            end
            rdd_pkg::FUNC_DROP: begin
                if (!failed) begin
                    if (held == 0) begin
                        failed = 1'b1;
                    end else begin
                        if (!backward) front_idx = front_idx + 6'd1;
                        held--;
                    end
                end
            end
            default: begin
                drains++;
                if (failed) begin
                    add_word(make_word(8'h00, 1'b1, 1'b0, 1'b1));
                end else if (held == 0) begin
                    add_word(make_word(8'h00, 1'b1, 1'b1, 1'b0));
                end else begin
                    for (i = 0; i < held; i++) begin
                        pos = backward ? (held - 1 - i) : i;
                        idx = front_idx + pos[5:0];
                        add_word(make_word(shadow_store[idx], (i + 1 == held), 1'b0, 1'b0));
                    end
                end
                front_idx = '0;
                held      = 0;
                backward  = 1'b0;
                failed    = 1'b0;
            end
        endcase
    endtask

    // valid stays high after a handshake so back-to-back words need no dip
    task automatic send_word(input rdd_pkg::func_t f, input logic [7:0] v);
        while (!steady && $urandom_range(99) < 18) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= v;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        deque_apply(f, v);
        words_in++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (drain_words.size() != 0) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        rdd_pkg::res_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            words_out++;
            if (drain_words.size() == 0) begin
                $error("unexpected result word: element %0h last %0b user %0b",
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
                mismatches++;
            end else begin
                want = drain_words[0];
                drain_words.delete(0);
                if (m_axis_tdata !== want.element) begin
                    $error("element: expected %0h, got %0h", want.element, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser[0] !== want.list_empty) begin
                    $error("list_empty: expected %0b, got %0b",
                           want.list_empty, m_axis_tuser[0]);
                    mismatches++;
                end
                if (m_axis_tuser[1] !== want.error) begin
                    $error("error: expected %0b, got %0b", want.error, m_axis_tuser[1]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 18);
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic test_push_finish();
        send_word(rdd_pkg::FUNC_PUSH, 8'h00);
        send_word(rdd_pkg::FUNC_PUSH, 8'hFF);
        send_word(rdd_pkg::FUNC_PUSH, 8'h5A);
        send_word(rdd_pkg::FUNC_PUSH, 8'hA5);
        send_word(rdd_pkg::FUNC_FINISH, 8'h00);
    endtask

    task automatic test_empty_finish();
        send_word(rdd_pkg::FUNC_FINISH, 8'hFF);
    endtask

    task automatic test_reverse_drop();
        send_word(rdd_pkg::FUNC_PUSH, 8'h01);
        send_word(rdd_pkg::FUNC_PUSH, 8'h02);
        send_word(rdd_pkg::FUNC_PUSH, 8'h03);
        send_word(rdd_pkg::FUNC_PUSH, 8'h04);
        send_word(rdd_pkg::FUNC_REVERSE, 8'h00);
        send_word(rdd_pkg::FUNC_DROP, 8'h00);
        send_word(rdd_pkg::FUNC_PUSH, 8'h77);
        send_word(rdd_pkg::FUNC_DROP, 8'hFF);
        send_word(rdd_pkg::FUNC_REVERSE, 8'hFF);
        send_word(rdd_pkg::FUNC_DROP, 8'h00);
        send_word(rdd_pkg::FUNC_REVERSE, 8'h00);
        send_word(rdd_pkg::FUNC_FINISH, 8'h00);
    endtask

    // drop on empty sets the sticky flag; reverse and drop then do nothing
    task automatic test_drop_on_empty();
        send_word(rdd_pkg::FUNC_DROP, 8'h00);
        send_word(rdd_pkg::FUNC_REVERSE, 8'h00);
        send_word(rdd_pkg::FUNC_DROP, 8'h00);
        send_word(rdd_pkg::FUNC_PUSH, 8'h33);
        send_word(rdd_pkg::FUNC_FINISH, 8'h00);
    endtask

    task automatic test_overflow();
        int i;
        for (i = 0; i < QUEUE_DEPTH; i++)
            send_word(rdd_pkg::FUNC_PUSH, 8'($urandom_range(255)));
        send_word(rdd_pkg::FUNC_PUSH, 8'hEE);
        send_word(rdd_pkg::FUNC_DROP, 8'h00);
        send_word(rdd_pkg::FUNC_PUSH, 8'h11);
        send_word(rdd_pkg::FUNC_REVERSE, 8'h00);
        send_word(rdd_pkg::FUNC_FINISH, 8'h00);
    endtask

    task automatic test_pause_for_drain();
        send_word(rdd_pkg::FUNC_PUSH, 8'hC3);
        send_word(rdd_pkg::FUNC_PUSH, 8'h3C);
        send_word(rdd_pkg::FUNC_FINISH, 8'h00);
        wait_drained();
        send_word(rdd_pkg::FUNC_FINISH, 8'h00);
    endtask

    task automatic test_random_runs();
        int base;
        int steps;
        int k;
        int pick;
        base = words_in;
        while (words_in < ITEM_TARGET) begin
            steady = (words_in - base >= 10) && (words_in - base < 45);
            if ($urandom_range(99) < 82) begin
                // well-formed run: mixed pushes, reverses, drops, then finish
                steps = ($urandom_range(11) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
                for (k = 0; k < steps; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 60 || held == 0)
                        send_word(rdd_pkg::FUNC_PUSH, 8'($urandom_range(255)));
                    else if (pick < 75)
                        send_word(rdd_pkg::FUNC_REVERSE, 8'($urandom_range(255)));
                    else
                        send_word(rdd_pkg::FUNC_DROP, 8'($urandom_range(255)));
                end
                send_word(rdd_pkg::FUNC_FINISH, 8'($urandom_range(255)));
                if ($urandom_range(4) == 0) wait_drained();
            end else begin
                steps = $urandom_range(1, 5);
                for (k = 0; k < steps; k++)
                    send_word(rdd_pkg::func_t'(2'($urandom_range(3))),
                              8'($urandom_range(255)));
            end
        end
        steady = 1'b0;
        send_word(rdd_pkg::FUNC_FINISH, 8'h00);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_push_finish();
        test_empty_finish();
        test_reverse_drop();
        test_drop_on_empty();
        test_overflow();
        test_pause_for_drain();
        test_random_runs();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d input words, checked %0d result words over %0d drains",
                 words_in, words_out, drains);
        $display("covered reversal, drops, drop on empty, %0d pushes into a full queue",
                 full_pushes);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
